[sv/raster_to_tiled_rgb565_writer_top_assert.svh]
// Assertion macros for the raster-to-tiled RGB565 writer checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef RASTER_TO_TILED_RGB565_WRITER_TOP_ASSERT_SVH
`define RASTER_TO_TILED_RGB565_WRITER_TOP_ASSERT_SVH

// Clocked check, off while reset is held.
`define RTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define RTT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rtt_pkg.sv]
// Shared constants for the raster-to-tiled RGB565 writer.
// No dependencies.
package rtt_pkg;

  localparam int TEX_SIZE_DEF = 128;

  localparam int COLOR_W  = 8;
  localparam int PIX565_W = 16;
  localparam int OFFSET_W = 15;
  localparam int WORD_W   = 2 * PIX565_W;
  localparam int SIZE_W   = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(128);

  // Truncate RGB888 to RGB565.
  function automatic logic [PIX565_W-1:0] to_rgb565(input logic [COLOR_W-1:0] r,
                                                    input logic [COLOR_W-1:0] g,
                                                    input logic [COLOR_W-1:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

[sv/rtt_pix_if.sv]
// Pixel channel: valid/ready handshake with one RGB888 pixel.
// Depends on rtt_pkg.
interface rtt_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rtt_pkg::COLOR_W-1:0] red;
  logic [rtt_pkg::COLOR_W-1:0] green;
  logic [rtt_pkg::COLOR_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

[sv/rtt_word_if.sv]
// Word channel: valid/ready handshake with one texel pair and its offset.
// Depends on rtt_pkg.
interface rtt_word_if;
  logic                         valid;
  logic                         ready;
  logic [rtt_pkg::OFFSET_W-1:0] byte_offset;
  logic [rtt_pkg::WORD_W-1:0]   texel_pair;
  logic                         last_of_image;

  modport source (output valid, byte_offset, texel_pair, last_of_image, input ready);
  modport sink   (input valid, byte_offset, texel_pair, last_of_image, output ready);
endinterface

[sv/raster_to_tiled_rgb565_writer_top.sv]
// Raster-to-tiled RGB565 writer: top level, single registered pass.
// Depends on rtt_pkg, rtt_pix_if and rtt_word_if.
//
//   channel | direction | handshake           | carries
//   --------+-----------+---------------------+------------------------------------
//   in_ch   | in        | valid/ready         | red, green, blue (RGB888 pixel)
//   out_ch  | out       | valid/ready         | byte_offset, texel_pair, last_of_image
//   cfg_*   | in        | cfg_we, no back-off | cfg_index, cfg_wdata
//
// One pixel is accepted per cycle, but for the stall below. A pixel that
// closes a word (odd column, or the lone last pixel of an odd-width row)
// shows its word on out_ch in the next cycle, from the single output register.
// A left pixel produces no word, so it is taken even while out_ch is stalled;
// a closing pixel waits only when the output register is full and not drained.
// rst_n is synchronous: counters, held pixel and out valid clear, the size
// registers return to 128. No clearing pass is needed.
module raster_to_tiled_rgb565_writer_top #(
  parameter int TEX_SIZE = rtt_pkg::TEX_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rtt_pix_if.sink                        in_ch,
  rtt_word_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rtt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Counter width covers a coordinate inside the texture; size width holds
  // TEX_SIZE itself; compare width covers both that and the 8-bit registers.
  localparam int CntW        = $clog2(TEX_SIZE);
  localparam int SzW         = $clog2(TEX_SIZE + 1);
  localparam int CmpW        = (SzW > rtt_pkg::SIZE_W) ? SzW : rtt_pkg::SIZE_W;
  localparam int TileW       = 2 * CntW;
  localparam int TilesPerRow = TEX_SIZE / 8;
  localparam int FullW       = TileW + 7;

  // Configuration and image position.
  logic [rtt_pkg::SIZE_W-1:0]   width_r, width_nxt;
  logic [rtt_pkg::SIZE_W-1:0]   height_r, height_nxt;
  logic [CntW-1:0]              col_r, col_nxt;
  logic [CntW-1:0]              row_r, row_nxt;
  logic [rtt_pkg::PIX565_W-1:0] held_r, held_nxt;

  // Output register.
  logic                         out_valid_r, out_valid_nxt;
  logic [rtt_pkg::OFFSET_W-1:0] offset_r, offset_nxt;
  logic [rtt_pkg::WORD_W-1:0]   pair_r, pair_nxt;
  logic                         last_r, last_nxt;

  logic [CmpW-1:0]              w_raw, h_raw, w_eff, h_eff;
  logic [CntW-1:0]              col, row, x_even;
  logic                         end_of_row, last_row, emit, accept, restart;
  logic [rtt_pkg::PIX565_W-1:0] pix;
  logic [TileW-1:0]             tile;
  logic [5:0]                   inner;
  logic [FullW-1:0]             full_off;

  // Clamp the size registers: zero acts as one, oversize as TEX_SIZE.
  always_comb begin
    w_raw = CmpW'(width_r);
    h_raw = CmpW'(height_r);
    priority if (w_raw == '0) begin
      w_eff = CmpW'(1);
    end else if (w_raw > CmpW'(TEX_SIZE)) begin
      w_eff = CmpW'(TEX_SIZE);
    end else begin
      w_eff = w_raw;
    end
    priority if (h_raw == '0) begin
      h_eff = CmpW'(1);
    end else if (h_raw > CmpW'(TEX_SIZE)) begin
      h_eff = CmpW'(TEX_SIZE);
    end else begin
      h_eff = h_raw;
    end
  end

  // Position of the pixel now at the input; fall back to zero if out of range.
  always_comb begin
    col        = (CmpW'(col_r) >= w_eff) ? '0 : col_r;
    row        = (CmpW'(row_r) >= h_eff) ? '0 : row_r;
    end_of_row = (CmpW'(col) + CmpW'(1)) == w_eff;
    last_row   = (CmpW'(row) + CmpW'(1)) == h_eff;
    emit       = col[0] | end_of_row;
  end

  // Left pixels never block; closing pixels need room in the output register.
  assign in_ch.ready = !emit || !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign restart     = cfg_we && ((cfg_index == rtt_pkg::REG_IMAGE_WIDTH) ||
                                  (cfg_index == rtt_pkg::REG_IMAGE_HEIGHT));

  // Tiled offset of the word's left texel: 8x8 tiles in row-major order,
  // Morton order inside a tile (x0,y0,x1,y1,x2,y2), two bytes per texel.
  always_comb begin
    pix      = rtt_pkg::to_rgb565(in_ch.red, in_ch.green, in_ch.blue);
    x_even   = {col[CntW-1:1], 1'b0};
    inner    = {row[2], x_even[2], row[1], x_even[1], row[0], x_even[0]};
    tile     = TileW'(row >> 3) * TileW'(TilesPerRow) + TileW'(x_even >> 3);
    full_off = {tile, inner, 1'b0};
  end

  // Next state.
  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    offset_nxt    = offset_r;
    pair_nxt      = pair_r;
    last_nxt      = last_r;

    if (cfg_we) begin
      unique case (cfg_index)
        rtt_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_wdata;
        rtt_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (restart) begin
      // Any write to the width or height register starts a new image.
      col_nxt  = '0;
      row_nxt  = '0;
      held_nxt = '0;
    end else if (accept) begin
      if (emit) begin
        out_valid_nxt = 1'b1;
        offset_nxt    = rtt_pkg::OFFSET_W'(full_off);
        pair_nxt      = col[0] ? {pix, held_r} : {{rtt_pkg::PIX565_W{1'b0}}, pix};
        last_nxt      = end_of_row && last_row;
        held_nxt      = '0;
      end else begin
        held_nxt = pix;
      end
      if (end_of_row) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row + CntW'(1);
      end else begin
        col_nxt = col + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= rtt_pkg::SIZE_RESET;
      height_r    <= rtt_pkg::SIZE_RESET;
      col_r       <= '0;
      row_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offset_r <= offset_nxt;
    pair_r   <= pair_nxt;
    last_r   <= last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_offset   = offset_r;
  assign out_ch.texel_pair    = pair_r;
  assign out_ch.last_of_image = last_r;

endmodule

[sv/rtt_checker.sv]
// Port-level checker for the raster-to-tiled RGB565 writer, bound to the top.
// Depends on rtt_pkg and raster_to_tiled_rgb565_writer_top_assert.svh.
`include "raster_to_tiled_rgb565_writer_top_assert.svh"

module rtt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rtt_pkg::OFFSET_W-1:0] out_byte_offset,
  input logic [rtt_pkg::WORD_W-1:0]   out_texel_pair,
  input logic                         out_last_of_image
);

  // A stalled word stays offered.
  `RTT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "word dropped while stalled")

  // A stalled word keeps its payload.
  `RTT_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_byte_offset) && $stable(out_texel_pair) && $stable(out_last_of_image), "stalled word changed")

  // Every word starts on a four-byte boundary.
  `RTT_ASSERT(a_offset_align, out_valid |-> out_byte_offset[1:0] == 2'b00, "offset not word aligned")

  // Reset empties the output register.
  `RTT_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "word offered right after reset")

endmodule

bind raster_to_tiled_rgb565_writer_top rtt_checker u_rtt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_byte_offset  (out_ch.byte_offset),
  .out_texel_pair   (out_ch.texel_pair),
  .out_last_of_image(out_ch.last_of_image)
);
